[rtl/sqs_pkg.sv]
package sqs_pkg;

  localparam int DEPTH   = 8;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ACC_W   = DATA_W + CNT_W;
  localparam int STEP_W  = $clog2(ACC_W + 1);
  localparam int FUNC_W  = 2;
  localparam int COUNT_W = 4;
  localparam int SUM_W   = 35;

  typedef logic        [ADDR_W-1:0]  addr_t;
  typedef logic        [CNT_W-1:0]   cnt_t;
  typedef logic signed [DATA_W-1:0]  data_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic        [STEP_W-1:0]  step_t;
  typedef logic        [FUNC_W-1:0]  func_t;
  typedef logic        [COUNT_W-1:0] count_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  localparam func_t FN_ENQ = 2'd0;
  localparam func_t FN_DEQ = 2'd1;
  localparam func_t FN_CLR = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

[rtl/sqs_if.sv]
interface sqs_req_if;
  logic                valid;
  logic                ready;
  sqs_pkg::func_t      func;
  sqs_pkg::data_t      value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface sqs_rsp_if;
  logic                valid;
  logic                ready;
  sqs_pkg::status_t    status;
  sqs_pkg::data_t      removed_value;
  sqs_pkg::count_t     count;
  sqs_pkg::sum_t       sum;
  sqs_pkg::data_t      average;
  sqs_pkg::data_t      minimum;
  sqs_pkg::data_t      maximum;

  modport source (output valid, status, removed_value, count, sum, average, minimum, maximum,
                  input ready);
  modport sink   (input valid, status, removed_value, count, sum, average, minimum, maximum,
                  output ready);
endinterface

[rtl/shifting_queue_with_statistics_top.sv]
// channel | dir | payload                                                   | handshake
// req     | in  | func, value                                               | valid/ready
// rsp     | out | status, removed_value, count, sum, average, minimum, max  | valid/ready
//
// One item at a time: an op state, a pop state for a dequeue, a walk over the held
// entries, a drain state for the memory read and a start state, then ACC_W (36)
// radix-2 divider steps and a result state; an empty queue goes from the walk to the result.
// Reset (rst, synchronous) empties the queue; memory contents stay undefined.
// A finished result waits in the output register while the next beat is taken.
module shifting_queue_with_statistics_top (
  input logic      clk,
  input logic      rst,
  sqs_req_if.sink  req,
  sqs_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_OP, S_POP, S_WALK, S_DRAIN, S_DSTART, S_DIV, S_DONE
  } state_t;

  state_t             state;
  sqs_pkg::func_t     func_q;
  sqs_pkg::data_t     value_q;
  sqs_pkg::status_t   status_q;
  sqs_pkg::data_t     removed_q;
  sqs_pkg::cnt_t      cnt;
  sqs_pkg::addr_t     head;
  sqs_pkg::addr_t     ptr;
  sqs_pkg::cnt_t      idx;
  logic               rd_vld;
  logic               first;
  sqs_pkg::acc_t      acc;
  sqs_pkg::data_t     mn;
  sqs_pkg::data_t     mx;
  sqs_pkg::data_t     avg_q;

  logic               rsp_valid;
  sqs_pkg::status_t   o_status;
  sqs_pkg::data_t     o_removed;
  sqs_pkg::count_t    o_count;
  sqs_pkg::sum_t      o_sum;
  sqs_pkg::data_t     o_avg;
  sqs_pkg::data_t     o_min;
  sqs_pkg::data_t     o_max;

  logic               we;
  sqs_pkg::addr_t     waddr;
  sqs_pkg::addr_t     raddr;
  logic [sqs_pkg::DATA_W-1:0] rdata;
  sqs_pkg::data_t     elem;
  logic [sqs_pkg::CNT_W:0] tail_sum;

  logic               div_start;
  logic               div_done;
  sqs_pkg::acc_t      quotient;

  function automatic sqs_pkg::addr_t inc(input sqs_pkg::addr_t a);
    sqs_pkg::addr_t r;
    if (a == sqs_pkg::addr_t'(sqs_pkg::DEPTH - 1)) begin
      r = '0;
    end else begin
      r = a + 1'b1;
    end
    return r;
  endfunction

  assign tail_sum = {1'b0, sqs_pkg::cnt_t'(head)} + {1'b0, cnt};
  assign waddr    = (tail_sum >= (sqs_pkg::CNT_W + 1)'(sqs_pkg::DEPTH))
                    ? sqs_pkg::addr_t'(tail_sum - (sqs_pkg::CNT_W + 1)'(sqs_pkg::DEPTH))
                    : sqs_pkg::addr_t'(tail_sum);
  assign we       = (state == S_OP) && (func_q == sqs_pkg::FN_ENQ) &&
                    (cnt != sqs_pkg::cnt_t'(sqs_pkg::DEPTH));
  assign raddr    = (state == S_OP) ? head : ptr;
  assign elem     = sqs_pkg::data_t'(rdata);
  assign div_start = (state == S_DSTART);

  sqs_ram #(.WIDTH(sqs_pkg::DATA_W), .DEPTH(sqs_pkg::DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (value_q),
    .raddr (raddr),
    .rdata (rdata)
  );

  sqs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      head      <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= 1'b0;
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (rd_vld) begin
        first <= 1'b0;
        if (first) begin
          acc <= sqs_pkg::acc_t'(elem);
          mn  <= elem;
          mx  <= elem;
        end else begin
          acc <= acc + sqs_pkg::acc_t'(elem);
          if (elem < mn) mn <= elem;
          if (elem > mx) mx <= elem;
        end
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            func_q  <= req.func;
            value_q <= req.value;
            state   <= S_OP;
          end
        end
        S_OP: begin
          status_q  <= sqs_pkg::ST_OK;
          removed_q <= '0;
          ptr       <= head;
          idx       <= '0;
          first     <= 1'b1;
          state     <= S_WALK;
          case (func_q)
            sqs_pkg::FN_ENQ: begin
              if (cnt == sqs_pkg::cnt_t'(sqs_pkg::DEPTH)) begin
                status_q <= sqs_pkg::ST_FULL;
              end else begin
                cnt <= cnt + 1'b1;
              end
            end
            sqs_pkg::FN_DEQ: begin
              if (cnt == '0) begin
                status_q <= sqs_pkg::ST_EMPTY;
              end else begin
                state <= S_POP;
              end
            end
            sqs_pkg::FN_CLR: begin
              cnt <= '0;
            end
            default: begin
            end
          endcase
        end
        S_POP: begin
          removed_q <= elem;
          head      <= inc(head);
          ptr       <= inc(head);
          cnt       <= cnt - 1'b1;
          state     <= S_WALK;
        end
        S_WALK: begin
          if (cnt == '0) begin
            state <= S_DONE;
          end else begin
            rd_vld <= 1'b1;
            ptr    <= inc(ptr);
            idx    <= idx + 1'b1;
            if (idx == cnt - 1'b1) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          state <= S_DSTART;
        end
        S_DSTART: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            avg_q <= quotient[sqs_pkg::DATA_W-1:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            o_status  <= status_q;
            o_removed <= removed_q;
            o_count   <= sqs_pkg::count_t'(cnt);
            if (cnt == '0) begin
              o_sum <= '0;
              o_avg <= '0;
              o_min <= '0;
              o_max <= '0;
            end else begin
              o_sum <= sqs_pkg::sum_t'(acc);
              o_avg <= avg_q;
              o_min <= mn;
              o_max <= mx;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = o_status;
  assign rsp.removed_value = o_removed;
  assign rsp.count         = o_count;
  assign rsp.sum           = o_sum;
  assign rsp.average       = o_avg;
  assign rsp.minimum       = o_min;
  assign rsp.maximum       = o_max;

endmodule

[rtl/sqs_ram.sv]
module sqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sqs_div.sv]
module sqs_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sqs_pkg::acc_t dividend,
  input  sqs_pkg::cnt_t divisor,
  output logic          done,
  output sqs_pkg::acc_t quotient
);

  logic [sqs_pkg::ACC_W-1:0] q;
  sqs_pkg::cnt_t             rem;
  sqs_pkg::cnt_t             dvs;
  sqs_pkg::step_t            step;
  logic                      active;
  logic                      neg;
  logic [sqs_pkg::CNT_W:0]   rem_sh;
  logic [sqs_pkg::CNT_W:0]   diff;
  logic                      ge;

  assign rem_sh = {rem, q[sqs_pkg::ACC_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs});
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q      <= dividend[sqs_pkg::ACC_W-1] ? -dividend : dividend;
        neg    <= dividend[sqs_pkg::ACC_W-1];
        dvs    <= divisor;
        rem    <= '0;
        step   <= sqs_pkg::step_t'(sqs_pkg::ACC_W);
        active <= 1'b1;
      end else if (active) begin
        q    <= {q[sqs_pkg::ACC_W-2:0], ge};
        rem  <= ge ? diff[sqs_pkg::CNT_W-1:0] : rem_sh[sqs_pkg::CNT_W-1:0];
        step <= step - 1'b1;
        if (step == sqs_pkg::step_t'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -sqs_pkg::acc_t'(q) : sqs_pkg::acc_t'(q);

endmodule

[rtl/sqs_checker.sv]
module sqs_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input sqs_pkg::status_t      status,
  input sqs_pkg::count_t       count,
  input sqs_pkg::sum_t         sum,
  input sqs_pkg::data_t        average,
  input sqs_pkg::data_t        minimum,
  input sqs_pkg::data_t        maximum
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result beat dropped while stalled");

  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == sqs_pkg::ST_FULL |->
      count == sqs_pkg::count_t'(sqs_pkg::DEPTH))
    else $error("full status with queue not full");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == sqs_pkg::ST_EMPTY |-> count == '0)
    else $error("empty status with entries held");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && count == '0 |->
      sum == '0 && average == '0 && minimum == '0 && maximum == '0)
    else $error("statistics not zero for empty queue");

  a_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && count != '0 |-> minimum <= average && average <= maximum)
    else $error("average outside minimum and maximum");

endmodule

bind shifting_queue_with_statistics_top sqs_checker u_sqs_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .count     (rsp.count),
  .sum       (rsp.sum),
  .average   (rsp.average),
  .minimum   (rsp.minimum),
  .maximum   (rsp.maximum)
);
